/* hw/rtl/urd_pkg.sv */
// Package for the radix digit converter: widths, limits and the digit character map.
package urd_pkg;

  localparam int VALUE_WIDTH    = 64;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int STORE_DEPTH    = 64;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int CNT_W          = ADDR_W + 1;
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES     = VALUE_WIDTH / BITS_PER_CYCLE;
  localparam int DIV_CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA  = CHAR_W'(8'h57);  // 'a' less ten
  localparam logic [RADIX_W-1:0] NUM_DIGITS = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] NUM_CHARS  = RADIX_W'(36);

  // Map a digit value to its lowercase ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < NUM_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < NUM_CHARS) begin
      c = CHAR_ALPHA + CHAR_W'(d);
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

/* hw/rtl/urd_if.sv */
// Handshake interfaces for the value input channel and the digit output channel.
interface urd_in_if;
  logic                           valid;
  logic                           ready;
  logic [urd_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface urd_out_if;
  logic                      valid;
  logic                      ready;
  logic [urd_pkg::CHAR_W-1:0] digit_char;
  logic                      last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* hw/rtl/unsigned_to_radix_digits.sv */
// Top level of the unsigned value to radix digit converter.
//
// Usage: one unsigned 64-bit value enters on din per item; for it the block
// sends one item per digit on dout, most significant digit first, as an ASCII
// character '0'-'9' then 'a'-'z'. last_digit marks the final digit. Zero
// gives the single character '0'.
// The radix register (2..36, reset 10) is written through cfg_we/cfg_wdata;
// writes outside 2..36 are dropped. Write it only while the block is idle.
// Timing: din.ready is high only while idle. Each digit costs one divide
// (start, the shared divider at 8 bits a cycle, write back); once every
// digit is stored, the digits are read back out of the digit store one at
// a time. The first digit appears only after the last divide.
// Reset clears the sequencer, the digit count and the output valid; the
// digit store needs no clearing. A stalled dout holds its item in the output
// register and the sequencer waits; no item is lost or repeated.
module unsigned_to_radix_digits (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [urd_pkg::RADIX_W-1:0] cfg_wdata,
  urd_in_if.sink                      din,
  urd_out_if.source                   dout
);
  import urd_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DIV_START = 3'd1;
  localparam logic [2:0] S_DIV_WAIT  = 3'd2;
  localparam logic [2:0] S_EMIT_RD   = 3'd3;
  localparam logic [2:0] S_EMIT_LD   = 3'd4;

  logic [2:0]             state;
  logic [RADIX_W-1:0]     radix;
  logic [VALUE_WIDTH-1:0] quotient_reg;
  logic [CNT_W-1:0]       digit_count;
  logic [ADDR_W-1:0]      emit_idx;

  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [RADIX_W-1:0]     div_rem;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [RADIX_W-1:0]     mem_wdata;
  logic [RADIX_W-1:0]     mem_rdata;

  logic                   in_take;
  logic                   out_load;
  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;

  // Radix register: keep the old value on an out-of-range write.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we && (cfg_wdata inside {[RADIX_MIN:RADIX_MAX]})) begin
      radix <= cfg_wdata;
    end
  end

  assign din.ready = (state == S_IDLE);
  assign in_take   = din.valid && din.ready;
  assign div_start = (state == S_DIV_START);

  // Output register is free when empty or being taken this cycle.
  assign out_load = (state == S_EMIT_LD) && (!out_valid || dout.ready);

  // Digit store write: a zero value writes '0' at once; otherwise each
  // remainder lands at the current digit count.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = digit_count[ADDR_W-1:0];
    mem_wdata = div_rem;
    if (in_take && (din.value[VALUE_WIDTH-1:0] == '0)) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '0;
    end else if ((state == S_DIV_WAIT) && div_done) begin
      mem_we = 1'b1;
    end
  end

  urd_div_unit u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (quotient_reg),
    .radix     (radix),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  urd_digit_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (emit_idx),
    .rdata (mem_rdata)
  );

  // Sequencer: divide until the quotient is zero, then read the digits back
  // from the highest index down.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      digit_count  <= '0;
      quotient_reg <= '0;
      emit_idx     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            quotient_reg <= din.value[VALUE_WIDTH-1:0];
            emit_idx     <= '0;
            if (din.value[VALUE_WIDTH-1:0] == '0) begin
              digit_count <= CNT_W'(1);
              state       <= S_EMIT_RD;
            end else begin
              digit_count <= '0;
              state       <= S_DIV_START;
            end
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            digit_count  <= digit_count + CNT_W'(1);
            quotient_reg <= div_quot;
            if ((div_quot == '0) || (digit_count == CNT_W'(STORE_DEPTH - 1))) begin
              emit_idx <= digit_count[ADDR_W-1:0];
              state    <= S_EMIT_RD;
            end else begin
              state <= S_DIV_START;
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_load) begin
            if (emit_idx == '0) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx - ADDR_W'(1);
              state    <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the item until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= digit_to_char(mem_rdata);
      out_last <= (emit_idx == '0);
    end
  end

  assign dout.valid      = out_valid;
  assign dout.digit_char = out_char;
  assign dout.last_digit = out_last;

endmodule

/* hw/rtl/urd_div_unit.sv */
// Shared divider: divides the running quotient by the radix, eight bits a cycle.
module urd_div_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [urd_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [urd_pkg::RADIX_W-1:0]     radix,
  output logic                            done,
  output logic [urd_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [urd_pkg::RADIX_W-1:0]     remainder
);
  import urd_pkg::*;

  logic                   busy;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [VALUE_WIDTH-1:0] work;
  logic [VALUE_WIDTH-1:0] work_next;
  logic [RADIX_W-1:0]     rem;
  logic [RADIX_W-1:0]     rem_next;
  logic [RADIX_W-1:0]     divisor;

  // Restoring division steps; the partial remainder stays below the divisor.
  always_comb begin
    logic [RADIX_W:0] t;
    work_next = work;
    rem_next  = rem;
    t         = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      t         = {rem_next, work_next[VALUE_WIDTH-1]};
      work_next = {work_next[VALUE_WIDTH-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t            = t - {1'b0, divisor};
        work_next[0] = 1'b1;
      end
      rem_next = t[RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      work    <= dividend;
      rem     <= '0;
      divisor <= radix;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

/* hw/rtl/urd_digit_ram.sv */
// Digit store: one write port, one registered read port.
module urd_digit_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [urd_pkg::ADDR_W-1:0]  waddr,
  input  logic [urd_pkg::RADIX_W-1:0] wdata,
  input  logic [urd_pkg::ADDR_W-1:0]  raddr,
  output logic [urd_pkg::RADIX_W-1:0] rdata
);
  import urd_pkg::*;

  logic [RADIX_W-1:0] digit_store [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      digit_store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= digit_store[raddr];
  end

endmodule
